// ===== rtl/core/flow_stats_jitter_tracker_defines.svh =====
// Assertion macros for the flow statistics block.
// Both macros use the clock and reset of the module that includes this file.
`ifndef FLOW_STATS_JITTER_TRACKER_DEFINES_SVH
`define FLOW_STATS_JITTER_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define FJT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define FJT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FJT_ASSERT(lbl, prop, msg)
`define FJT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/fjt_pkg.sv =====
package fjt_pkg;

  localparam int unsigned DropReasons = 4;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned TimeW = 48;
  localparam int unsigned LenW  = 16;
  localparam int unsigned RsnW  = 2;
  localparam int unsigned PktW  = 48;
  localparam int unsigned ByteW = 56;
  localparam int unsigned JitW  = TimeW + 1;
  localparam int unsigned JitShift = 4;

  // Reasons above what the reason field can carry never reach the store.
  localparam int unsigned DropDepth = (DropReasons < (1 << RsnW)) ? DropReasons : (1 << RsnW);
  localparam int unsigned DropAw    = (DropDepth > 1) ? $clog2(DropDepth) : 1;

  typedef enum logic [CmdW-1:0] {
    CMD_TX   = 2'd0,
    CMD_RX   = 2'd1,
    CMD_DROP = 2'd2,
    CMD_RST  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [TimeW-1:0] now;
    logic [LenW-1:0]  byte_count;
    logic [TimeW-1:0] send_stamp;
    logic [RsnW-1:0]  drop_reason;
  } fjt_in_t;

  typedef struct packed {
    logic [PktW-1:0]         tx_packet_count;
    logic [ByteW-1:0]        tx_byte_count;
    logic [PktW-1:0]         rx_packet_count;
    logic [ByteW-1:0]        rx_byte_count;
    logic [TimeW-1:0]        jitter_estimate;
    logic signed [ByteW-1:0] delay_total;
    logic [PktW-1:0]         lost_packet_count;
    logic signed [TimeW-1:0] active_duration;
    logic [PktW-1:0]         reason_drop_packets;
    logic [ByteW-1:0]        reason_drop_bytes;
    logic [PktW-1:0]         all_drop_packets;
    logic [ByteW-1:0]        all_drop_bytes;
  } fjt_out_t;

  typedef struct packed {
    logic [PktW-1:0]  pkts;
    logic [ByteW-1:0] bytes;
  } drop_ent_t;

  // State after one event, as handed to the result stage.
  typedef struct packed {
    logic [PktW-1:0]         tx_pk;
    logic [ByteW-1:0]        tx_by;
    logic [PktW-1:0]         rx_pk;
    logic [ByteW-1:0]        rx_by;
    logic [JitW-1:0]         jit;
    logic signed [ByteW-1:0] dly;
    logic [TimeW-1:0]        first_tx;
    logic [TimeW-1:0]        last_rx;
    drop_ent_t               rsn;
    drop_ent_t               tot;
  } fjt_snap_t;

  function automatic logic [PktW-1:0] sat_inc(logic [PktW-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic logic [ByteW-1:0] sat_add_len(logic [ByteW-1:0] a, logic [LenW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {{(ByteW + 1 - LenW){1'b0}}, b};
    return s[ByteW] ? {ByteW{1'b1}} : s[ByteW-1:0];
  endfunction

  function automatic logic reason_ok(logic [RsnW-1:0] r);
    return 32'(r) < DropReasons;
  endfunction

endpackage

// ===== rtl/core/flow_stats_jitter_tracker.sv =====
// Channel | direction | payload   | handshake
// in      | input     | fjt_in_t  | in_valid_i / in_stall_o
// out     | output    | fjt_out_t | out_valid_o / out_stall_i
//
// Events are taken one per cycle unless in_stall_o is high, and pass stages 1-3 to out_q.
// The counter and jitter update sits in one stage, which sets the one-cycle rate.
// The per-reason drop counters live in a small memory read one stage ahead, with a
// bypass from the write of the preceding event; valid bits stand in for a clearing pass.
// rst_ni clears all counters at once. Up to four events are held while out_stall_i is high.
`include "flow_stats_jitter_tracker_defines.svh"

module flow_stats_jitter_tracker import fjt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fjt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fjt_out_t out_data_o
);

  localparam int unsigned TrW = TimeW + 1;
  localparam int unsigned DW  = TimeW + 2;

  // Pipeline control.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s3_move, s2_move, s1_move, in_acc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s3_move  = s3_valid_q && out_free;
  assign s3_free  = !s3_valid_q || out_free;
  assign s2_move  = s2_valid_q && s3_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_move  = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign in_acc   = in_valid_i && s1_free;

  assign in_stall_o  = !s1_free;
  assign out_valid_o = out_valid_q;

  // Transit time of the arriving packet and of the last receive accepted.
  logic signed [TrW-1:0] in_tr;
  logic signed [TrW-1:0] prev_tr_q;
  logic                  rx_seen_q;

  assign in_tr = $signed({1'b0, in_data_i.now}) - $signed({1'b0, in_data_i.send_stamp});

  // Stage 1: change in transit time.
  fjt_in_t               s1_q;
  logic signed [TrW-1:0] s1_tr_q, s1_prev_q;
  logic                  s1_first_q;
  logic signed [DW-1:0]  s1_d;
  logic [DW-1:0]         s1_abs;
  logic [TrW-1:0]        s1_mag;
  logic [DropAw-1:0]     s1_idx;

  assign s1_d   = DW'(s1_tr_q) - DW'(s1_prev_q);
  assign s1_abs = s1_d[DW-1] ? -s1_d : s1_d;
  assign s1_mag = s1_first_q ? '0 : s1_abs[TrW-1:0];
  assign s1_idx = s1_q.drop_reason[DropAw-1:0];

  // Stage 2: state update.
  fjt_in_t               s2_q;
  logic signed [TrW-1:0] s2_tr_q;
  logic [TrW-1:0]        s2_mag_q;
  drop_ent_t             drop_mem [DropDepth];
  logic [DropDepth-1:0]  vld_q;
  drop_ent_t             rd_q, byp_q;
  logic                  rd_vld_q, byp_sel_q;

  logic [PktW-1:0]         tx_pk_q, tx_pk_d, rx_pk_q, rx_pk_d;
  logic [ByteW-1:0]        tx_by_q, tx_by_d, rx_by_q, rx_by_d;
  logic [JitW-1:0]         jit_q, jit_d;
  logic signed [ByteW-1:0] dly_q, dly_d;
  logic [TimeW-1:0]        first_tx_q, first_tx_d, last_rx_q, last_rx_d;
  drop_ent_t               tot_q, tot_d;

  logic [DropAw-1:0]       s2_idx;
  logic                    s2_rok, s2_wr, s2_rst;
  drop_ent_t               s2_cur, s2_new, s2_rsn;
  logic signed [JitW:0]    jdiff, jstep, jsum;
  logic signed [ByteW:0]   dsum;
  fjt_snap_t               snap_d;

  assign s2_idx = s2_q.drop_reason[DropAw-1:0];
  assign s2_rok = reason_ok(s2_q.drop_reason);
  assign s2_rst = (s2_q.cmd == CMD_RST);
  assign s2_wr  = (s2_q.cmd == CMD_DROP) && s2_rok;
  assign s2_cur = byp_sel_q ? byp_q : (rd_vld_q ? rd_q : '0);

  always_comb begin
    s2_new.pkts  = sat_inc(s2_cur.pkts);
    s2_new.bytes = sat_add_len(s2_cur.bytes, s2_q.byte_count);
    s2_rsn       = s2_wr ? s2_new : s2_cur;
    if (!s2_rok || s2_rst) begin
      s2_rsn = '0;
    end
  end

  // The jitter moves by a sixteenth of the gap, rounded towards minus infinity.
  assign jdiff = $signed({1'b0, s2_mag_q}) - $signed({1'b0, jit_q});
  assign jstep = jdiff >>> JitShift;
  assign jsum  = $signed({1'b0, jit_q}) + jstep;
  assign dsum  = $signed({dly_q[ByteW-1], dly_q})
               + $signed({{(ByteW + 1 - TrW){s2_tr_q[TrW-1]}}, s2_tr_q});

  always_comb begin
    tx_pk_d    = tx_pk_q;
    tx_by_d    = tx_by_q;
    rx_pk_d    = rx_pk_q;
    rx_by_d    = rx_by_q;
    jit_d      = jit_q;
    dly_d      = dly_q;
    first_tx_d = first_tx_q;
    last_rx_d  = last_rx_q;
    tot_d      = tot_q;
    case (s2_q.cmd)
      CMD_TX: begin
        if (tx_pk_q == '0) begin
          first_tx_d = s2_q.now;
        end
        tx_pk_d = sat_inc(tx_pk_q);
        tx_by_d = sat_add_len(tx_by_q, s2_q.byte_count);
      end
      CMD_RX: begin
        rx_pk_d   = sat_inc(rx_pk_q);
        rx_by_d   = sat_add_len(rx_by_q, s2_q.byte_count);
        jit_d     = jsum[JitW-1:0];
        last_rx_d = s2_q.now;
        if (dsum[ByteW] != dsum[ByteW-1]) begin
          dly_d = dsum[ByteW] ? {1'b1, {(ByteW - 1){1'b0}}} : {1'b0, {(ByteW - 1){1'b1}}};
        end else begin
          dly_d = dsum[ByteW-1:0];
        end
      end
      CMD_DROP: begin
        tot_d.pkts  = sat_inc(tot_q.pkts);
        tot_d.bytes = sat_add_len(tot_q.bytes, s2_q.byte_count);
      end
      CMD_RST: begin
        tx_pk_d    = '0;
        tx_by_d    = '0;
        rx_pk_d    = '0;
        rx_by_d    = '0;
        jit_d      = '0;
        dly_d      = '0;
        first_tx_d = '1;
        last_rx_d  = '0;
        tot_d      = '0;
      end
      default: begin
        tx_pk_d = tx_pk_q;
      end
    endcase
  end

  always_comb begin
    snap_d.tx_pk    = tx_pk_d;
    snap_d.tx_by    = tx_by_d;
    snap_d.rx_pk    = rx_pk_d;
    snap_d.rx_by    = rx_by_d;
    snap_d.jit      = jit_d;
    snap_d.dly      = dly_d;
    snap_d.first_tx = first_tx_d;
    snap_d.last_rx  = last_rx_d;
    snap_d.rsn      = s2_rsn;
    snap_d.tot      = tot_d;
  end

  // Stage 3: derived result fields.
  fjt_snap_t      s3_q;
  fjt_out_t       res_d, out_q;
  logic [TimeW:0] adiff;

  assign adiff = {1'b0, s3_q.last_rx} - {1'b0, s3_q.first_tx};

  always_comb begin
    res_d.tx_packet_count = s3_q.tx_pk;
    res_d.tx_byte_count   = s3_q.tx_by;
    res_d.rx_packet_count = s3_q.rx_pk;
    res_d.rx_byte_count   = s3_q.rx_by;
    res_d.jitter_estimate = s3_q.jit[JitW-1] ? {TimeW{1'b1}} : s3_q.jit[TimeW-1:0];
    res_d.delay_total     = s3_q.dly;
    if ((s3_q.tx_pk != '0) && (s3_q.tx_pk >= s3_q.rx_pk)) begin
      res_d.lost_packet_count = s3_q.tx_pk - s3_q.rx_pk;
    end else begin
      res_d.lost_packet_count = '0;
    end
    if (s3_q.rx_pk == '0) begin
      res_d.active_duration = '0;
    end else if (adiff[TimeW] != adiff[TimeW-1]) begin
      res_d.active_duration = adiff[TimeW] ? {1'b1, {(TimeW - 1){1'b0}}}
                                           : {1'b0, {(TimeW - 1){1'b1}}};
    end else begin
      res_d.active_duration = adiff[TimeW-1:0];
    end
    res_d.reason_drop_packets = s3_q.rsn.pkts;
    res_d.reason_drop_bytes   = s3_q.rsn.bytes;
    res_d.all_drop_packets    = s3_q.tot.pkts;
    res_d.all_drop_bytes      = s3_q.tot.bytes;
  end

  assign out_data_o = out_q;

  // Control and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rx_seen_q   <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      byp_sel_q   <= 1'b0;
      tx_pk_q     <= '0;
      tx_by_q     <= '0;
      rx_pk_q     <= '0;
      rx_by_q     <= '0;
      jit_q       <= '0;
      dly_q       <= '0;
      first_tx_q  <= '1;
      last_rx_q   <= '0;
      tot_q       <= '0;
    end else begin
      s1_valid_q  <= in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
      s2_valid_q  <= s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_q);
      s3_valid_q  <= s2_move ? 1'b1 : (s3_move ? 1'b0 : s3_valid_q);
      out_valid_q <= s3_move ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
      if (in_acc) begin
        if (in_data_i.cmd == CMD_RX) begin
          rx_seen_q <= 1'b1;
        end else if (in_data_i.cmd == CMD_RST) begin
          rx_seen_q <= 1'b0;
        end
      end
      if (s1_move) begin
        rd_vld_q  <= vld_q[s1_idx];
        // The entry read now may be the one the departing event writes at this edge.
        byp_sel_q <= s2_move && (s2_rst || (s2_wr && (s2_idx == s1_idx)));
      end
      if (s2_move) begin
        if (s2_rst) begin
          vld_q <= '0;
        end else if (s2_wr) begin
          vld_q[s2_idx] <= 1'b1;
        end
        tx_pk_q    <= tx_pk_d;
        tx_by_q    <= tx_by_d;
        rx_pk_q    <= rx_pk_d;
        rx_by_q    <= rx_by_d;
        jit_q      <= jit_d;
        dly_q      <= dly_d;
        first_tx_q <= first_tx_d;
        last_rx_q  <= last_rx_d;
        tot_q      <= tot_d;
      end
    end
  end

  // Payload registers and the drop store.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= in_data_i;
      s1_tr_q    <= in_tr;
      s1_prev_q  <= prev_tr_q;
      s1_first_q <= !rx_seen_q;
      if (in_data_i.cmd == CMD_RX) begin
        prev_tr_q <= in_tr;
      end
    end
    if (s1_move) begin
      s2_q     <= s1_q;
      s2_tr_q  <= s1_tr_q;
      s2_mag_q <= s1_mag;
      rd_q     <= drop_mem[s1_idx];
      byp_q    <= s2_rst ? '0 : s2_new;
    end
    if (s2_move && s2_wr) begin
      drop_mem[s2_idx] <= s2_new;
    end
    if (s2_move) begin
      s3_q <= snap_d;
    end
    if (s3_move) begin
      out_q <= res_d;
    end
  end

  `FJT_ASSERT_NEXT(a_accept_lands, in_acc, s1_valid_q, "accepted transaction missing from stage 1")
  `FJT_ASSERT_NEXT(a_rst_clears_store, s2_move && s2_rst, vld_q == '0, "drop store not cleared")
  `FJT_ASSERT_NEXT(a_write_marks_valid, s2_move && s2_wr, vld_q[$past(s2_idx)], "drop entry not marked")
  `FJT_ASSERT(a_rx_seen_tracks, (!s1_valid_q && !s2_valid_q) |-> (rx_seen_q == (rx_pk_q != '0)), "first-receive tracking out of step")

endmodule
